/* src/jde_pkg.sv */
// ----------------------------------------------------------------------------
// Junction diffusion package
// Payload types, pipeline stage map and fixed-point constants shared by the
// junction diffusion datapath and its checker.
// ----------------------------------------------------------------------------
package jde_pkg;

   localparam int COUNT_WIDTH = 48;

   localparam logic [63:0] COUNT_MAX = 64'((65'd1 << COUNT_WIDTH) - 65'd1);

   localparam int SQRT_STEPS    = 32;
   localparam int DIV_STEPS     = 64;
   localparam int EXP_TERMS     = 13;
   localparam int EXP_INT_STEPS = 31;

   localparam int ST_IN      = 0;
   localparam int ST_A       = ST_IN + 1;
   localparam int ST_B0      = ST_A + 1;
   localparam int ST_C       = ST_B0 + SQRT_STEPS;
   localparam int ST_D       = ST_C + 1;
   localparam int ST_E       = ST_D + 1;
   localparam int ST_F0      = ST_E + 1;
   localparam int ST_G       = ST_F0 + DIV_STEPS;
   localparam int ST_H0      = ST_G + 1;
   localparam int ST_I0      = ST_H0 + 3 * EXP_TERMS;
   localparam int ST_J       = ST_I0 + EXP_INT_STEPS;
   localparam int ST_K       = ST_J + 1;
   localparam int ST_L       = ST_K + 1;
   localparam int ST_M       = ST_L + 1;
   localparam int PIPE_DEPTH = ST_M + 1;

   localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
   localparam logic [30:0] EXP_NEG1_Q32 = 31'd1580030169;
   localparam int          RECIP_SHIFT  = 36;

   // Reciprocals floor(2^36 / n) for the Horner divisors n = 13 down to 1.
   localparam logic [36:0] RECIP_Q36 [0:EXP_TERMS-1] = '{
      37'd5286113595,  37'd5726623061,  37'd6247225157,  37'd6871947673,
      37'd7635497415,  37'd8589934592,  37'd9817068105,  37'd11453246122,
      37'd13743895347, 37'd17179869184, 37'd22906492245, 37'd34359738368,
      37'd68719476736
   };

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] my_count;
      logic [COUNT_WIDTH-1:0] other_count;
      logic [31:0]            my_diff_const;
      logic [31:0]            other_diff_const;
      logic [31:0]            junction_scale;
      logic [31:0]            first_volume;
      logic [31:0]            second_volume;
   } jde_req_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] new_my_count;
      logic [COUNT_WIDTH-1:0] new_other_count;
      logic                   skipped;
   } jde_rsp_type;

   typedef struct packed {
      logic        skip;
      logic        kpos;
      logic [63:0] mine;
      logic [63:0] other;
   } jde_carry_type;

   typedef struct packed {
      logic [31:0] v1;
      logic [31:0] v2;
   } jde_vol_type;

   typedef struct packed {
      logic [63:0] x;
      logic [63:0] w;
   } jde_xw_type;

endpackage

/* src/junction_diffusion_exp_euler.sv */
// ----------------------------------------------------------------------------
// Junction diffusion exponential-Euler step
// Fully pipelined fixed-point update of one voxel pair across a junction.
//
//   channel   ports                          direction  transfer
//   request   start, busy, req_data          in         start && !busy
//   response  rsp_strobe, rsp_data           out        rsp_strobe
//   config    csr_write_en, csr_write_data   in         csr_write_en
//
// One item enters per cycle; results leave in the order of their transfers.
// The depth is set by the 32-step square root, the 64-step dividers, three
// stages per Horner term of the exponential and 31 scaling stages.
// Reset is synchronous; busy is high only during reset.
// The receiver cannot stall, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
module junction_diffusion_exp_euler (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  jde_pkg::jde_req_type req_data,
   output logic                rsp_strobe,
   output jde_pkg::jde_rsp_type rsp_data,
   input  logic                csr_write_en,
   input  logic [31:0]         csr_write_data
);
   import jde_pkg::*;

   logic [31:0]           time_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;
   jde_carry_type         cr_ff  [0:ST_L];
   jde_vol_type           vol_ff [0:ST_G-2];
   logic [31:0]           scl_ff [0:ST_C-1];
   jde_xw_type            xw_ff  [0:ST_J-ST_G-1];

   logic [31:0] dm_ff, do_ff;
   logic [63:0] prod_ff;
   logic [63:0] sq_v_ff [0:SQRT_STEPS-1];
   logic [63:0] sq_r_ff [0:SQRT_STEPS-1];
   logic [63:0] k_in, k_ff;
   logic [63:0] kdt_lo_ff, kdt_hi_ff, ov_lo_ff, ov_hi_ff;
   logic [95:0] nx_ff, nw_ff;
   logic [31:0] dx_rem_ff [0:DIV_STEPS-1];
   logic [63:0] dx_num_ff [0:DIV_STEPS-1];
   logic [63:0] dx_quo_ff [0:DIV_STEPS-1];
   logic        dx_sat_ff [0:DIV_STEPS-1];
   logic [31:0] dw_rem_ff [0:DIV_STEPS-1];
   logic [63:0] dw_num_ff [0:DIV_STEPS-1];
   logic [63:0] dw_quo_ff [0:DIV_STEPS-1];
   logic        dw_sat_ff [0:DIV_STEPS-1];
   logic [31:0] ht_ff  [0:EXP_TERMS-1];
   logic [31:0] ht2_ff [0:EXP_TERMS-1];
   logic [31:0] hq_ff  [0:EXP_TERMS-1];
   logic [32:0] ha_ff  [0:EXP_TERMS-1];
   logic [32:0] ea_ff  [0:EXP_INT_STEPS-1];
   logic [64:0] mcl_ff, mch_ff, wcl_ff, wch_ff;
   logic [63:0] wxll_ff, wxlh_ff, wxhl_ff, wxhh_ff;
   logic [63:0] mc_ff, wc_ff, wxs_ff, nm_ff;
   jde_rsp_type rsp_ff;

   assign busy       = reset;
   assign rsp_strobe = vld_ff[PIPE_DEPTH-1];
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         vld_ff  <= '0;
      end else begin
         if (csr_write_en) begin
            time_ff <= csr_write_data;
         end
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], start};
      end
   end

   assign k_in = sq_r_ff[SQRT_STEPS-1][31:0] * scl_ff[ST_C-1];

   for (genvar s = 0; s <= ST_L; s++) begin : g_carry
      localparam int PREV = (s == 0) ? 0 : s - 1;
      always_ff @(posedge clock) begin
         if (s == ST_IN) begin
            cr_ff[s].skip  <= (req_data.my_diff_const == '0) ||
                              (req_data.other_diff_const == '0);
            cr_ff[s].kpos  <= 1'b0;
            cr_ff[s].mine  <= 64'(req_data.my_count);
            cr_ff[s].other <= 64'(req_data.other_count);
         end else if (s == ST_C) begin
            cr_ff[s] <= '{skip: cr_ff[PREV].skip, kpos: (k_in != '0),
                          mine: cr_ff[PREV].mine, other: cr_ff[PREV].other};
         end else begin
            cr_ff[s] <= cr_ff[PREV];
         end
      end
   end

   for (genvar s = 0; s <= ST_G - 2; s++) begin : g_vol
      localparam int PREV = (s == 0) ? 0 : s - 1;
      always_ff @(posedge clock) begin
         if (s == ST_IN) begin
            vol_ff[s].v1 <= req_data.first_volume;
            vol_ff[s].v2 <= req_data.second_volume;
         end else begin
            vol_ff[s] <= vol_ff[PREV];
         end
      end
   end

   for (genvar s = 0; s < ST_C; s++) begin : g_scale
      localparam int PREV = (s == 0) ? 0 : s - 1;
      always_ff @(posedge clock) begin
         if (s == ST_IN) begin
            scl_ff[s] <= req_data.junction_scale;
         end else begin
            scl_ff[s] <= scl_ff[PREV];
         end
      end
   end

   always_ff @(posedge clock) begin
      dm_ff   <= req_data.my_diff_const;
      do_ff   <= req_data.other_diff_const;
      prod_ff <= dm_ff * do_ff;
      k_ff    <= k_in;
      kdt_lo_ff <= k_ff[31:0] * time_ff;
      kdt_hi_ff <= k_ff[63:32] * time_ff;
      ov_lo_ff  <= cr_ff[ST_C].other[31:0] * vol_ff[ST_C].v1;
      ov_hi_ff  <= cr_ff[ST_C].other[63:32] * vol_ff[ST_C].v1;
      nx_ff <= {kdt_hi_ff, 32'd0} + {32'd0, kdt_lo_ff};
      nw_ff <= {ov_hi_ff, 32'd0} + {32'd0, ov_lo_ff};
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * j);
      logic [63:0] v_i, r_i, t_i;
      always_comb begin
         v_i = (j == 0) ? prod_ff : sq_v_ff[(j == 0) ? 0 : j-1];
         r_i = (j == 0) ? 64'd0   : sq_r_ff[(j == 0) ? 0 : j-1];
         t_i = r_i + SQ_BIT;
      end
      always_ff @(posedge clock) begin
         if (v_i >= t_i) begin
            sq_v_ff[j] <= v_i - t_i;
            sq_r_ff[j] <= (r_i >> 1) + SQ_BIT;
         end else begin
            sq_v_ff[j] <= v_i;
            sq_r_ff[j] <= r_i >> 1;
         end
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [31:0] xr, wr, dx, dw;
      logic [63:0] xn, wn, xq, wq;
      logic        xs, ws, xge, wge;
      logic [32:0] xr2, wr2;
      always_comb begin
         dx = vol_ff[ST_F0+j-1].v1;
         dw = vol_ff[ST_F0+j-1].v2;
         if (j == 0) begin
            xr = nx_ff[95:64];
            xn = nx_ff[63:0];
            xq = '0;
            xs = (nx_ff[95:64] >= dx);
            wr = nw_ff[95:64];
            wn = nw_ff[63:0];
            wq = '0;
            ws = (nw_ff[95:64] >= dw);
         end else begin
            xr = dx_rem_ff[(j == 0) ? 0 : j-1];
            xn = dx_num_ff[(j == 0) ? 0 : j-1];
            xq = dx_quo_ff[(j == 0) ? 0 : j-1];
            xs = dx_sat_ff[(j == 0) ? 0 : j-1];
            wr = dw_rem_ff[(j == 0) ? 0 : j-1];
            wn = dw_num_ff[(j == 0) ? 0 : j-1];
            wq = dw_quo_ff[(j == 0) ? 0 : j-1];
            ws = dw_sat_ff[(j == 0) ? 0 : j-1];
         end
         xr2 = {xr, xn[63]};
         wr2 = {wr, wn[63]};
         xge = (xr2 >= {1'b0, dx});
         wge = (wr2 >= {1'b0, dw});
      end
      always_ff @(posedge clock) begin
         dx_rem_ff[j] <= xge ? 32'(xr2 - {1'b0, dx}) : xr2[31:0];
         dx_num_ff[j] <= {xn[62:0], 1'b0};
         dx_quo_ff[j] <= {xq[62:0], xge};
         dx_sat_ff[j] <= xs;
         dw_rem_ff[j] <= wge ? 32'(wr2 - {1'b0, dw}) : wr2[31:0];
         dw_num_ff[j] <= {wn[62:0], 1'b0};
         dw_quo_ff[j] <= {wq[62:0], wge};
         dw_sat_ff[j] <= ws;
      end
   end

   for (genvar s = ST_G; s < ST_J; s++) begin : g_xw
      localparam int PREV = (s == ST_G) ? 0 : s - ST_G - 1;
      always_ff @(posedge clock) begin
         if (s == ST_G) begin
            xw_ff[0].x <= dx_sat_ff[DIV_STEPS-1] ? '1 : dx_quo_ff[DIV_STEPS-1];
            xw_ff[0].w <= (dw_sat_ff[DIV_STEPS-1] || dw_quo_ff[DIV_STEPS-1] > COUNT_MAX)
                          ? COUNT_MAX : dw_quo_ff[DIV_STEPS-1];
         end else begin
            xw_ff[s-ST_G] <= xw_ff[PREV];
         end
      end
   end

   for (genvar j = 0; j < EXP_TERMS; j++) begin : g_horner
      localparam logic [3:0] TERM_N = 4'(EXP_TERMS - j);
      logic [32:0] a_i;
      logic [64:0] fa;
      logic [68:0] qp;
      logic [35:0] qn;
      logic [31:0] rr;
      logic [32:0] qq;
      always_comb begin
         a_i = (j == 0) ? ONE_Q32 : ha_ff[(j == 0) ? 0 : j-1];
         fa  = xw_ff[3*j].x[31:0] * a_i;
         qp  = ht_ff[j] * RECIP_Q36[j];
         qn  = hq_ff[j] * TERM_N;
         rr  = ht2_ff[j] - qn[31:0];
         qq  = {1'b0, hq_ff[j]} + 33'(rr >= 32'(TERM_N));
      end
      always_ff @(posedge clock) begin
         ht_ff[j]  <= fa[63:32];
         ht2_ff[j] <= ht_ff[j];
         hq_ff[j]  <= qp[RECIP_SHIFT+31:RECIP_SHIFT];
         ha_ff[j]  <= ONE_Q32 - qq;
      end
   end

   for (genvar j = 0; j < EXP_INT_STEPS; j++) begin : g_scale_e
      logic [32:0] a_i;
      logic [63:0] ep;
      always_comb begin
         a_i = (j == 0) ? ha_ff[EXP_TERMS-1] : ea_ff[(j == 0) ? 0 : j-1];
         ep  = a_i * EXP_NEG1_Q32;
      end
      always_ff @(posedge clock) begin
         if (xw_ff[ST_I0+j-1-ST_G].x[36:32] > 5'(j)) begin
            ea_ff[j] <= {1'b0, ep[63:32]};
         end else begin
            ea_ff[j] <= a_i;
         end
      end
   end

   logic [32:0]  c_val, c_inv;
   jde_xw_type   xw_j;
   jde_carry_type cr_j;
   logic [127:0] wx_sum;
   logic [95:0]  wx_sh;
   logic [63:0]  mine_l, other_m, nm_v, delta, no_v, dn;
   logic [63:0]  rsp_ff_in_nm;

   always_comb begin
      xw_j   = xw_ff[ST_J-ST_G-1];
      cr_j   = cr_ff[ST_J-1];
      c_val  = (xw_j.x[63:37] != '0) ? 33'd0 : ea_ff[EXP_INT_STEPS-1];
      c_inv  = ONE_Q32 - c_val;
      wx_sum = (128'(wxhh_ff) << 64) + (128'(wxlh_ff) << 32) +
               (128'(wxhl_ff) << 32) + 128'(wxll_ff);
      wx_sh  = wx_sum[127:32];
   end

   always_ff @(posedge clock) begin
      mcl_ff  <= cr_j.mine[31:0] * c_val;
      mch_ff  <= cr_j.mine[63:32] * c_val;
      wcl_ff  <= xw_j.w[31:0] * c_inv;
      wch_ff  <= xw_j.w[63:32] * c_inv;
      wxll_ff <= xw_j.w[31:0] * xw_j.x[31:0];
      wxlh_ff <= xw_j.w[31:0] * xw_j.x[63:32];
      wxhl_ff <= xw_j.w[63:32] * xw_j.x[31:0];
      wxhh_ff <= xw_j.w[63:32] * xw_j.x[63:32];
      mc_ff   <= 64'(mch_ff + (mcl_ff >> 32));
      wc_ff   <= 64'(wch_ff + (wcl_ff >> 32));
      wxs_ff  <= (wx_sh[95:64] != '0 || wx_sh[63:0] > COUNT_MAX) ? COUNT_MAX : wx_sh[63:0];
   end

   always_comb begin
      mine_l = cr_ff[ST_K].mine;
      if (mine_l != '0 && cr_ff[ST_K].kpos) begin
         nm_v = (wc_ff > COUNT_MAX || mc_ff > COUNT_MAX - wc_ff) ? COUNT_MAX : mc_ff + wc_ff;
      end else if (mine_l == '0) begin
         nm_v = wxs_ff;
      end else begin
         nm_v = mine_l;
      end
   end

   always_ff @(posedge clock) begin
      nm_ff <= nm_v;
   end

   always_comb begin
      other_m = cr_ff[ST_L].other;
      delta   = nm_ff - cr_ff[ST_L].mine;
      dn      = cr_ff[ST_L].mine - nm_ff;
      rsp_ff_in_nm = nm_ff;
      if (nm_ff >= cr_ff[ST_L].mine) begin
         if (delta > other_m) begin
            rsp_ff_in_nm = cr_ff[ST_L].mine + other_m;
            no_v         = '0;
         end else begin
            no_v = other_m - delta;
         end
      end else begin
         no_v = (dn > COUNT_MAX || other_m > COUNT_MAX - dn) ? COUNT_MAX : other_m + dn;
      end
   end

   always_ff @(posedge clock) begin
      if (cr_ff[ST_L].skip) begin
         rsp_ff.new_my_count    <= cr_ff[ST_L].mine[COUNT_WIDTH-1:0];
         rsp_ff.new_other_count <= other_m[COUNT_WIDTH-1:0];
         rsp_ff.skipped         <= 1'b1;
      end else begin
         rsp_ff.new_my_count    <= rsp_ff_in_nm[COUNT_WIDTH-1:0];
         rsp_ff.new_other_count <= no_v[COUNT_WIDTH-1:0];
         rsp_ff.skipped         <= 1'b0;
      end
   end

endmodule

/* src/jde_checker.sv */
// ----------------------------------------------------------------------------
// Junction diffusion port checker
// Checks response timing and the pass-through case against the request
// transfers seen on the ports of the top level.
// ----------------------------------------------------------------------------
module jde_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input jde_pkg::jde_req_type req_data,
   input logic                 rsp_strobe,
   input jde_pkg::jde_rsp_type rsp_data
);
   import jde_pkg::*;

   a_rsp_after_req : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_DEPTH))
      else $error("response without a matching request transfer");

   a_skip_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.skipped ==
         ($past(req_data.my_diff_const, PIPE_DEPTH) == '0 ||
          $past(req_data.other_diff_const, PIPE_DEPTH) == '0)))
      else $error("skip flag does not follow the diffusion constants");

   a_skip_pass : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.skipped |->
         rsp_data.new_my_count == $past(req_data.my_count, PIPE_DEPTH) &&
         rsp_data.new_other_count == $past(req_data.other_count, PIPE_DEPTH))
      else $error("skipped transfer did not pass the counts through");

endmodule

bind junction_diffusion_exp_euler jde_checker u_jde_checker (.*);
